// ===== rtl/emrt_pkg.sv =====
// Package for the epoch mark ring tracker: sizes, codes, transaction types, FSM states.
package emrt_pkg;

  localparam int MARK_SLOTS = 64;
  localparam int SLOT_W     = (MARK_SLOTS > 1) ? $clog2(MARK_SLOTS) : 1;
  localparam int EPOCH_W    = 32;
  localparam int OFFSET_W   = 32;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_INIT      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUBLISH   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEW_EPOCH = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WRITTEN   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_STALE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DURABLE_EPOCH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CURRENT_EPOCH = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [EPOCH_W-1:0]  epoch;
    logic [OFFSET_W-1:0] committed_offset;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] range_begin;
    logic [OFFSET_W-1:0] range_end;
    logic [OFFSET_W-1:0] durable_offset;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EVAL,
    S_WRITE_NEXT
  } state_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(MARK_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

// ===== rtl/epoch_mark_ring_tracker.sv =====
// Epoch mark ring tracker: mark ring memory, ring pointers, offsets and control FSM.
// From accept to result strobe: init, publish and unused codes end in S_EXEC;
// written ends in S_EVAL; new epoch ends there when refused, in S_WRITE_NEXT on
// a push; query repeats S_EXEC, one read per stale mark skipped, single read port.
// A new transaction is accepted in the cycle its predecessor's result is shown;
// the receiver cannot stall the result strobe.
// Synchronous active-low reset clears pointers and offsets and loads the initial
// epochs 0 and 1; the mark memory is not cleared, an init must come first.
module epoch_mark_ring_tracker import emrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic [EPOCH_W-1:0]  old_epoch;
    logic [EPOCH_W-1:0]  new_epoch;
    logic [OFFSET_W-1:0] begin_off;
    logic [OFFSET_W-1:0] end_off;
  } mark_t;

  mark_t mark_mem [MARK_SLOTS];
  mark_t rd_data_r;

  state_t state_r, state_nxt;
  in_t    op_r;

  logic [SLOT_W-1:0]   oldest_r, oldest_nxt;
  logic [SLOT_W-1:0]   current_r, current_nxt;
  logic [OFFSET_W-1:0] durable_r, durable_nxt;
  logic [OFFSET_W-1:0] committed_r, committed_nxt;
  logic [EPOCH_W-1:0]  init_durable_epoch_r;
  logic [EPOCH_W-1:0]  init_current_epoch_r;

  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  mark_t               wr_data;

  logic                accept;
  logic [SLOT_W-1:0]   cur_next;
  logic                is_read_op;

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cur_next   = next_slot(current_r);
  assign is_read_op = (op_r.func == FUNC_NEW_EPOCH) || (op_r.func == FUNC_QUERY) ||
                      (op_r.func == FUNC_WRITTEN);

  // mark memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mark_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mark_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= S_IDLE;
      oldest_r             <= '0;
      current_r            <= '0;
      durable_r            <= '0;
      committed_r          <= '0;
      out_valid_r          <= 1'b0;
      init_durable_epoch_r <= '0;
      init_current_epoch_r <= EPOCH_W'(1);
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      current_r   <= current_nxt;
      durable_r   <= durable_nxt;
      committed_r <= committed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_INIT_DURABLE_EPOCH: init_durable_epoch_r <= cfg_data;
          CFG_INIT_CURRENT_EPOCH: init_current_epoch_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = is_read_op ? S_EVAL : S_IDLE;
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        priority case (op_r.func)
          FUNC_NEW_EPOCH: begin
            if ((op_r.epoch > rd_data_r.new_epoch) && (cur_next != oldest_r)) begin
              state_nxt = S_WRITE_NEXT;
            end
          end
          FUNC_QUERY: begin
            if ((oldest_r != current_r) && (rd_data_r.new_epoch < op_r.epoch)) begin
              state_nxt = S_EXEC;
            end
          end
          default: ;
        endcase
      end
      S_WRITE_NEXT: state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = oldest_r;
    wr_en         = 1'b0;
    wr_addr       = current_r;
    wr_data       = rd_data_r;
    oldest_nxt    = oldest_r;
    current_nxt   = current_r;
    durable_nxt   = durable_r;
    committed_nxt = committed_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    out_data_nxt.status         = STAT_OK;
    out_data_nxt.range_begin    = '0;
    out_data_nxt.range_end      = '0;
    out_data_nxt.durable_offset = durable_r;

    unique case (state_r)
      S_IDLE: ;
      S_EXEC: begin
        priority case (op_r.func)
          FUNC_INIT: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data       = '{old_epoch: init_durable_epoch_r,
                              new_epoch: init_current_epoch_r,
                              begin_off: '0, end_off: '0};
            oldest_nxt    = '0;
            current_nxt   = '0;
            durable_nxt   = '0;
            committed_nxt = '0;
            out_valid_nxt = 1'b1;
            out_data_nxt.durable_offset = '0;
          end
          FUNC_PUBLISH: begin
            committed_nxt = op_r.committed_offset;
            out_valid_nxt = 1'b1;
          end
          FUNC_NEW_EPOCH: begin
            rd_en   = 1'b1;
            rd_addr = current_r;
          end
          FUNC_QUERY, FUNC_WRITTEN: begin
            rd_en   = 1'b1;
            rd_addr = oldest_r;
          end
          default: out_valid_nxt = 1'b1;
        endcase
      end
      S_EVAL: begin
        priority case (op_r.func)
          FUNC_NEW_EPOCH: begin
            if (op_r.epoch <= rd_data_r.new_epoch) begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = STAT_STALE;
            end else if (cur_next == oldest_r) begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = STAT_FULL;
            end else begin
              // close the current mark
              wr_en           = 1'b1;
              wr_addr         = current_r;
              wr_data.end_off = committed_r;
            end
          end
          FUNC_QUERY: begin
            if ((oldest_r != current_r) && (rd_data_r.new_epoch < op_r.epoch)) begin
              oldest_nxt = next_slot(oldest_r);
            end else begin
              out_valid_nxt = 1'b1;
              if (rd_data_r.new_epoch == op_r.epoch) begin
                out_data_nxt.range_begin = rd_data_r.begin_off;
                out_data_nxt.range_end   = rd_data_r.end_off;
                if (oldest_r == current_r) begin
                  wr_en                  = 1'b1;
                  wr_addr                = oldest_r;
                  wr_data.end_off        = committed_r;
                  out_data_nxt.range_end = committed_r;
                end
              end
            end
          end
          FUNC_WRITTEN: begin
            out_valid_nxt = 1'b1;
            if (rd_data_r.new_epoch == op_r.epoch) begin
              durable_nxt                 = rd_data_r.end_off;
              out_data_nxt.durable_offset = rd_data_r.end_off;
              if (oldest_r != current_r) begin
                oldest_nxt = next_slot(oldest_r);
              end
            end
          end
          default: out_valid_nxt = 1'b1;
        endcase
      end
      S_WRITE_NEXT: begin
        // push the new mark; rd_data_r still holds the closed one
        wr_en         = 1'b1;
        wr_addr       = cur_next;
        wr_data       = '{old_epoch: rd_data_r.new_epoch, new_epoch: op_r.epoch,
                          begin_off: committed_r, end_off: '0};
        current_nxt   = cur_next;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) != S_IDLE)
    else $error("result strobe without a transaction in progress");

  a_result_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while still busy");

  a_accept_execs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == S_EXEC)
    else $error("accepted transaction did not start");

  a_push_completes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE_NEXT |=> (out_valid_r && current_r == next_slot($past(current_r))))
    else $error("mark push did not advance current slot");

  a_ring_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE_NEXT) |-> (cur_next != oldest_r))
    else $error("push into oldest slot");
`endif

endmodule
